// ----- src/stl_pkg.sv -----
// Shared types and constants for the segment table height lookup core.
// Holds the request/response structs, the segment entry layout and the codes.
// No dependencies.
package stl_pkg;

	// table depth and derived widths
	localparam int MAX_SEGMENTS = 16;
	localparam int IDX_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
	localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);

	// request modes
	localparam logic [1:0] MODE_QUERY  = 2'd0;
	localparam logic [1:0] MODE_APPEND = 2'd1;
	localparam logic [1:0] MODE_SETEND = 2'd2;
	localparam logic [1:0] MODE_REMOVE = 2'd3;

	// response status codes
	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_NOHIT = 2'd1;
	localparam logic [1:0] STAT_FULL  = 2'd2;
	localparam logic [1:0] STAT_EMPTY = 2'd3;

	typedef struct packed {
		logic [1:0]         mode;
		logic signed [15:0] start_x;
		logic signed [15:0] start_y;
		logic signed [15:0] end_x;
		logic signed [15:0] end_y;
		logic signed [15:0] query_x;
	} req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [23:0] height;
	} rsp_t;

	// one stored segment, right endpoint in the low half
	typedef struct packed {
		logic signed [15:0] x1;
		logic signed [15:0] y1;
		logic signed [15:0] x2;
		logic signed [15:0] y2;
	} seg_t;

endpackage

// ----- src/segment_table_height_lookup_core.sv -----
// Segment table height lookup core: stack of line segments in a synchronous
// memory, with scan, multiply and serial divide for height queries.
// Depends on stl_pkg.
//
// Usage:
//   Requests enter on req/req_valid/req_ready, one response per request leaves
//   on rsp/rsp_valid/rsp_ready. One request is worked on at a time; req_ready
//   is high only while the core is idle.
//   Append, set end and remove update the table in the accept cycle and give
//   their response from the output register after passing the done state.
//   A query reads the stored segments one per cycle from the segment memory
//   (registered read), multiplies once, then runs a restoring divide that
//   produces one quotient bit per cycle for a 24-bit quotient. A query on an
//   empty table skips the scan; one with no spanning segment ends after the
//   scan without the divide.
//   The response sits in an output register; while the receiver stalls the
//   core may take and work one more request, then holds that finished result
//   and takes no further request until the output register frees up.
//   Reset empties the table (count to zero); memory contents are not cleared
//   and entries above the count are never read.
module segment_table_height_lookup_core
	import stl_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SCAN = 3'd1;
	localparam logic [2:0] ST_WAIT = 3'd2;
	localparam logic [2:0] ST_MUL  = 3'd3;
	localparam logic [2:0] ST_DIV  = 3'd4;
	localparam logic [2:0] ST_FIN  = 3'd5;
	localparam logic [2:0] ST_DONE = 3'd6;

	localparam int QUO_W = 24;
	localparam int DCNT_W = $clog2(QUO_W);

	logic [2:0]         state_q;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   idx_q;
	logic [CNT_W-1:0]   cnt_last;
	logic signed [15:0] qx_q;
	logic               found_q;
	seg_t               win_q;
	logic               rd_vld_s1;
	seg_t               rd_data_s1;
	logic [15:0]        rem_q;
	logic [QUO_W-1:0]   quo_q;
	logic [15:0]        dx_q;
	logic               neg_q;
	logic [DCNT_W-1:0]  div_cnt_q;
	logic [1:0]         res_status_q;
	logic signed [23:0] res_height_q;
	logic               rsp_valid_q;
	rsp_t               rsp_q;

	seg_t seg_mem [MAX_SEGMENTS];

	logic accept;
	logic app_we;
	logic end_we;
	logic rd_en;
	logic hit;
	logic out_load;

	logic signed [16:0] dy;
	logic [15:0]        dy_mag;
	logic signed [16:0] dq;
	logic signed [16:0] dx;
	logic [31:0]        prod;
	logic [16:0]        trial;
	logic               ge;
	logic [16:0]        diff;
	logic [QUO_W-1:0]   quo_sgn;

	assign req_ready = (state_q == ST_IDLE);
	assign accept    = req_valid && req_ready;
	assign cnt_last  = count_q - CNT_W'(1);

	// table updates happen in the accept cycle
	assign app_we = accept && (req.mode == MODE_APPEND) && (count_q < CNT_W'(MAX_SEGMENTS));
	assign end_we = accept && (req.mode == MODE_SETEND) && (count_q != '0);
	assign rd_en  = (state_q == ST_SCAN);

	// segment memory, one write and one registered read port
	always_ff @(posedge clk) begin
		if (app_we) begin
			seg_mem[count_q[IDX_W-1:0]] <= '{x1: req.start_x, y1: req.start_y,
				x2: req.end_x, y2: req.end_y};
		end else if (end_we) begin
			seg_mem[cnt_last[IDX_W-1:0]].x2 <= req.end_x;
			seg_mem[cnt_last[IDX_W-1:0]].y2 <= req.end_y;
		end
		if (rd_en) begin
			rd_data_s1 <= seg_mem[idx_q[IDX_W-1:0]];
		end
	end

	// span test on the entry read last cycle
	assign hit = (rd_data_s1.x1 < qx_q) && (rd_data_s1.x2 > qx_q);

	// interpolation operands from the winning segment
	always_comb begin
		dy     = {win_q.y2[15], win_q.y2} - {win_q.y1[15], win_q.y1};
		dy_mag = dy[16] ? 16'(-dy) : dy[15:0];
		dq     = {qx_q[15], qx_q} - {win_q.x1[15], win_q.x1};
		dx     = {win_q.x2[15], win_q.x2} - {win_q.x1[15], win_q.x1};
		prod   = dy_mag * dq[15:0];
	end

	// one restoring divide step
	always_comb begin
		trial   = {rem_q, quo_q[QUO_W-1]};
		ge      = trial >= {1'b0, dx_q};
		diff    = trial - {1'b0, dx_q};
		quo_sgn = neg_q ? QUO_W'(-quo_q) : quo_q;
	end

	assign out_load = (state_q == ST_DONE) && (!rsp_valid_q || rsp_ready);

	// control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			count_q      <= '0;
			idx_q        <= '0;
			qx_q         <= '0;
			found_q      <= 1'b0;
			rd_vld_s1    <= 1'b0;
			rem_q        <= '0;
			quo_q        <= '0;
			dx_q         <= '0;
			neg_q        <= 1'b0;
			div_cnt_q    <= '0;
			res_status_q <= STAT_OK;
			res_height_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						res_height_q <= '0;
						case (req.mode)
							MODE_QUERY: begin
								qx_q    <= req.query_x;
								found_q <= 1'b0;
								idx_q   <= '0;
								if (count_q == '0) begin
									res_status_q <= STAT_NOHIT;
									state_q      <= ST_DONE;
								end else begin
									res_status_q <= STAT_OK;
									state_q      <= ST_SCAN;
								end
							end
							MODE_APPEND: begin
								state_q <= ST_DONE;
								if (count_q < CNT_W'(MAX_SEGMENTS)) begin
									res_status_q <= STAT_OK;
									count_q      <= count_q + CNT_W'(1);
								end else begin
									res_status_q <= STAT_FULL;
								end
							end
							MODE_SETEND: begin
								state_q      <= ST_DONE;
								res_status_q <= (count_q == '0) ? STAT_EMPTY : STAT_OK;
							end
							default: begin
								state_q <= ST_DONE;
								if (count_q == '0) begin
									res_status_q <= STAT_EMPTY;
								end else begin
									res_status_q <= STAT_OK;
									count_q      <= cnt_last;
								end
							end
						endcase
					end
				end
				ST_SCAN: begin
					rd_vld_s1 <= 1'b1;
					idx_q     <= idx_q + CNT_W'(1);
					if (idx_q == cnt_last) begin
						state_q <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					rd_vld_s1 <= 1'b0;
					state_q   <= ST_MUL;
				end
				ST_MUL: begin
					if (!found_q) begin
						res_status_q <= STAT_NOHIT;
						state_q      <= ST_DONE;
					end else begin
						rem_q     <= prod[31:16];
						quo_q     <= {prod[15:0], 8'h00};
						dx_q      <= dx[15:0];
						neg_q     <= dy[16];
						div_cnt_q <= '0;
						state_q   <= ST_DIV;
					end
				end
				ST_DIV: begin
					rem_q     <= ge ? diff[15:0] : trial[15:0];
					quo_q     <= {quo_q[QUO_W-2:0], ge};
					div_cnt_q <= div_cnt_q + DCNT_W'(1);
					if (div_cnt_q == DCNT_W'(QUO_W - 1)) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					res_status_q <= STAT_OK;
					res_height_q <= {win_q.y1, 8'h00} + quo_sgn;
					state_q      <= ST_DONE;
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			// last spanning segment wins
			if (rd_vld_s1 && hit) begin
				found_q <= 1'b1;
			end
		end
	end

	// winning segment capture
	always_ff @(posedge clk) begin
		if (rd_vld_s1 && hit) begin
			win_q <= rd_data_s1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (out_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			rsp_q <= '{status: res_status_q, height: res_height_q};
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ----- bench/tb_segment_table_height_lookup_core.sv -----
`timescale 1ns / 1ps
// Testbench for segment_table_height_lookup_core: directed and random table edits and
// height queries, each response checked against a behavioral table model.
// Depends on stl_pkg and the core.
module tb_segment_table_height_lookup_core;
	import stl_pkg::*;

	// expected responses from a behavioral copy of the segment table
	class segment_height_scoreboard;
		seg_t seg_table[MAX_SEGMENTS];
		int   seg_count;
		rsp_t expected_rsps[$];
		int   failures;

		function new();
			seg_count = 0;
			failures = 0;
		endfunction

		// apply an accepted request to the table and queue its response
		function void note_request(req_t r);
			rsp_t   e;
			bit     found;
			int     win;
			longint dy, dq, dx, h;
			e.status = STAT_OK;
			e.height = '0;
			case (r.mode)
				MODE_QUERY: begin
					found = 1'b0;
					win = 0;
					// last segment strictly spanning the position wins
					for (int i = 0; i < seg_count; i++) begin
						if (int'(seg_table[i].x1) < int'(r.query_x) &&
						    int'(seg_table[i].x2) > int'(r.query_x)) begin
							win = i;
							found = 1'b1;
						end
					end
					if (!found) begin
						e.status = STAT_NOHIT;
					end else begin
						dy = longint'(seg_table[win].y2) - longint'(seg_table[win].y1);
						dq = longint'(r.query_x) - longint'(seg_table[win].x1);
						dx = longint'(seg_table[win].x2) - longint'(seg_table[win].x1);
						// divide truncates toward zero, result in Q16.8
						h = longint'(seg_table[win].y1) * 256 + (dy * dq * 256) / dx;
						e.height = h[23:0];
					end
				end
				MODE_APPEND: begin
					if (seg_count >= MAX_SEGMENTS) begin
						e.status = STAT_FULL;
					end else begin
						seg_table[seg_count].x1 = r.start_x;
						seg_table[seg_count].y1 = r.start_y;
						seg_table[seg_count].x2 = r.end_x;
						seg_table[seg_count].y2 = r.end_y;
						seg_count++;
					end
				end
				MODE_SETEND: begin
					if (seg_count == 0) begin
						e.status = STAT_EMPTY;
					end else begin
						seg_table[seg_count - 1].x2 = r.end_x;
						seg_table[seg_count - 1].y2 = r.end_y;
					end
				end
				default: begin
					if (seg_count == 0)
						e.status = STAT_EMPTY;
					else
						seg_count--;
				end
			endcase
			expected_rsps.push_back(e);
		endfunction

		// compare one response with the oldest expectation
		function void check_response(rsp_t a);
			rsp_t e;
			if (expected_rsps.size() == 0) begin
				$error("response with none expected: status %0d height %0d",
					a.status, a.height);
				failures++;
				return;
			end
			e = expected_rsps.pop_front();
			if (a.status !== e.status) begin
				$error("status: expected %0d, actual %0d", e.status, a.status);
				failures++;
			end
			if (a.height !== e.height) begin
				$error("height: expected %0d, actual %0d", e.height, a.height);
				failures++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	req_t req;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	segment_height_scoreboard sb = new();
	int send_idle;
	int recv_idle = 0;
	int stall_left = 0;

	segment_table_height_lookup_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	always #5 clk = ~clk;

	// receiver stalls: mostly short, a few long, no new ones start when recv_idle is zero
	always @(negedge clk) begin
		if (stall_left > 0) begin
			rsp_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (recv_idle != 0 &&
		             $urandom_range(0, 99) < ((recv_idle == 1) ? 15 : 35)) begin
			rsp_ready <= 1'b0;
			stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
			                                          : $urandom_range(0, 3);
		end else begin
			rsp_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready)
			sb.check_response(rsp);
	end

	function automatic int rand_between(int lo, int hi);
		return lo + int'($urandom_range(0, hi - lo));
	endfunction

	function automatic int pick_gap(int level);
		int roll;
		if (level == 0)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < ((level == 1) ? 70 : 40))
			return 0;
		if (roll < 95)
			return rand_between(1, 3);
		return rand_between(10, 30);
	endfunction

	function automatic req_t make_req(logic [1:0] mode, int sx, int sy, int ex, int ey,
	                                  int qx);
		req_t r;
		r.mode = mode;
		r.start_x = 16'(sx);
		r.start_y = 16'(sy);
		r.end_x = 16'(ex);
		r.end_y = 16'(ey);
		r.query_x = 16'(qx);
		return r;
	endfunction

	function automatic int rand_coord(bit wide);
		return wide ? rand_between(-32768, 32767) : rand_between(-300, 300);
	endfunction

	// right end for a segment starting at x1: mostly spanning, sometimes degenerate
	function automatic int rand_right_end(int x1, bit wide);
		int x2;
		if (x1 > 32765 || $urandom_range(0, 9) == 0) begin
			x2 = x1 + 1 - rand_between(0, 20);
			return (x2 < -32768) ? -32768 : x2;
		end
		x2 = x1 + rand_between(2, wide ? 65535 : 400);
		return (x2 > 32767) ? 32767 : x2;
	endfunction

	function automatic req_t rand_request(bit growing);
		int          roll, x1, idx, lo, hi, qx;
		bit          wide;
		logic [95:0] noise;
		req_t        r;
		wide = ($urandom_range(0, 3) == 0);
		// unshaped noise: every field random
		if ($urandom_range(0, 99) < 8) begin
			noise = {$urandom, $urandom, $urandom};
			r = noise[$bits(req_t)-1:0];
			return r;
		end
		r = make_req(MODE_QUERY, rand_coord(1), rand_coord(1), rand_coord(1),
			rand_coord(1), rand_coord(1));
		roll = $urandom_range(0, 99);
		if (roll < (growing ? 35 : 10)) begin
			x1 = wide ? rand_between(-32768, 32765) : rand_between(-300, 300);
			r.mode = MODE_APPEND;
			r.start_x = 16'(x1);
			r.start_y = 16'(rand_coord(wide));
			r.end_x = 16'(rand_right_end(x1, wide));
			r.end_y = 16'(rand_coord(wide));
		end else if (roll < (growing ? 45 : 20)) begin
			r.mode = MODE_SETEND;
			x1 = (sb.seg_count > 0) ? int'(sb.seg_table[sb.seg_count - 1].x1)
			                        : rand_coord(wide);
			r.end_x = 16'(rand_right_end(x1, wide));
			r.end_y = 16'(rand_coord(wide));
		end else if (roll < 55) begin
			r.mode = MODE_REMOVE;
		end else begin
			r.mode = MODE_QUERY;
			qx = rand_coord(wide);
			// mostly aim inside a stored segment
			if (sb.seg_count > 0 && $urandom_range(0, 99) < 65) begin
				idx = $urandom_range(0, sb.seg_count - 1);
				lo = int'(sb.seg_table[idx].x1) + 1;
				hi = int'(sb.seg_table[idx].x2) - 1;
				if (hi >= lo)
					qx = rand_between(lo, hi);
			end
			r.query_x = 16'(qx);
		end
		return r;
	endfunction

	// drive one request and wait until it is taken
	task automatic send_request(req_t r);
		int gap;
		gap = pick_gap(send_idle);
		@(negedge clk);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		sb.note_request(r);
	endtask

	initial begin
		int  phase_left;
		bit  growing;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		send_idle = 0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		// directed: empty table cases, extreme segments, strict span edges
		send_request(make_req(MODE_QUERY, 0, 0, 0, 0, 0));
		send_request(make_req(MODE_SETEND, 0, 0, 5, 5, 0));
		send_request(make_req(MODE_REMOVE, 0, 0, 0, 0, 0));
		send_request(make_req(MODE_APPEND, -32768, -32768, 32767, 32767, 0));
		send_request(make_req(MODE_QUERY, 0, 0, 0, 0, 0));
		send_request(make_req(MODE_QUERY, 0, 0, 0, 0, -32767));
		send_request(make_req(MODE_QUERY, 0, 0, 0, 0, 32766));
		send_request(make_req(MODE_QUERY, 0, 0, 0, 0, -32768));
		send_request(make_req(MODE_QUERY, 0, 0, 0, 0, 32767));
		send_request(make_req(MODE_SETEND, 0, 0, 32767, -32768, 0));
		send_request(make_req(MODE_QUERY, 0, 0, 0, 0, 1));
		send_request(make_req(MODE_APPEND, 5, 100, 5, -100, 0));
		send_request(make_req(MODE_APPEND, 100, 7, -100, -7, 0));
		send_request(make_req(MODE_APPEND, -10, 32767, 10, -32768, 0));
		send_request(make_req(MODE_QUERY, 0, 0, 0, 0, -9));
		send_request(make_req(MODE_QUERY, 0, 0, 0, 0, 5));
		// fill the table, then one append too many
		recv_idle = 2;
		send_idle = 2;
		while (sb.seg_count < MAX_SEGMENTS)
			send_request(make_req(MODE_APPEND, rand_between(-50, 0), rand_coord(0),
				rand_between(2, 50), rand_coord(0), 0));
		send_request(make_req(MODE_APPEND, 0, 0, 10, 10, 0));
		send_request(make_req(MODE_QUERY, 0, 0, 0, 0, 1));

		// random: phases alternate between growing and shrinking the table
		phase_left = 0;
		growing = 1'b0;
		for (int n = 0; n < 1350; n++) begin
			if (phase_left == 0) begin
				phase_left = rand_between(40, 120);
				growing = ~growing;
				send_idle = $urandom_range(0, 2);
				recv_idle = $urandom_range(0, 2);
			end
			phase_left--;
			send_request(rand_request(growing));
		end
		@(negedge clk);
		req_valid <= 1'b0;

		while (sb.expected_rsps.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
		if (sb.failures == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// run limit
	initial begin
		#9_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule

// ----- sim.f -----
src/stl_pkg.sv
src/segment_table_height_lookup_core.sv
bench/tb_segment_table_height_lookup_core.sv
